@@ sv/tset_pkg.sv @@
// Package for the time sorted event table.
// Holds field widths, operation, status and move codes, and the broadcast
// operation struct. Depends on nothing.
package tset_pkg;

	localparam int KEY_W = 48;
	localparam int ID_W  = 16;
	localparam int POS_W = 8;
	localparam int CNT_W = 9;

	localparam logic [1:0] FN_INS = 2'd0;
	localparam logic [1:0] FN_DEL = 2'd1;
	localparam logic [1:0] FN_UPD = 2'd2;
	localparam logic [1:0] FN_NOP = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_FULL      = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STS_RANGE     = 2'd3;

	typedef enum logic [1:0] {
		MV_HOLD,
		MV_LEFT,
		MV_RIGHT,
		MV_NEW
	} move_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  tid;
		logic [POS_W-1:0] pos;
		logic             en;
	} op_t;

endpackage

@@ sv/tset_cell.sv @@
// One slot of the sorted table: holds a key and an id, compares them with
// the broadcast operation and moves data to or from its neighbors.
// Depends on tset_pkg.
module tset_cell import tset_pkg::*; #(
	parameter int TABLE_DEPTH = 256,
	parameter int IDX = 0,
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  op_t              op,
	input  logic [CW-1:0]    cnt,
	input  logic             cmp_en,
	input  logic             apply_en,
	input  logic             f_l,
	input  logic             f_r,
	input  logic             pre,
	input  logic             pre_l,
	input  logic [ID_W-1:0]  new_id,
	input  logic [KEY_W-1:0] left_key,
	input  logic [ID_W-1:0]  left_id,
	input  logic [KEY_W-1:0] right_key,
	input  logic [ID_W-1:0]  right_id,
	output logic [KEY_W-1:0] key,
	output logic [ID_W-1:0]  id,
	output logic             flag,
	output logic             hit
);

	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  id_q;
	logic             flag_q;
	logic             flag_d;
	logic             valid;
	logic             lt_pos;
	logic             is_pos;
	move_t            mv;

	assign valid  = 32'(IDX) < 32'(cnt);
	assign lt_pos = 32'(IDX) < 32'(op.pos);
	assign is_pos = 32'(IDX) == 32'(op.pos);

	always_comb begin
		unique case (op.func)
			FN_INS: flag_d = valid && !(key_q > op.key);
			FN_DEL: flag_d = valid && (id_q == op.tid);
			FN_UPD: flag_d = valid && !is_pos &&
				(lt_pos ? (key_q <= op.key) : (key_q < op.key));
			default: flag_d = 1'b0;
		endcase
	end

	always_comb begin
		mv = MV_HOLD;
		if (op.en) begin
			unique case (op.func)
				FN_INS: begin
					if (!flag_q) mv = f_l ? MV_NEW : MV_LEFT;
				end
				FN_DEL: begin
					if (pre) mv = MV_RIGHT;
				end
				FN_UPD: begin
					if (lt_pos) begin
						if (!flag_q) mv = f_l ? MV_NEW : MV_LEFT;
					end else if (is_pos) begin
						if (!f_l) mv = MV_LEFT;
						else if (f_r) mv = MV_RIGHT;
						else mv = MV_NEW;
					end else begin
						if (flag_q) mv = f_r ? MV_RIGHT : MV_NEW;
					end
				end
				default: mv = MV_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) flag_q <= flag_d;
		if (apply_en) begin
			unique case (mv)
				MV_LEFT: begin
					key_q <= left_key;
					id_q  <= left_id;
				end
				MV_RIGHT: begin
					key_q <= right_key;
					id_q  <= right_id;
				end
				MV_NEW: begin
					key_q <= op.key;
					id_q  <= new_id;
				end
				default: begin
					key_q <= key_q;
					id_q  <= id_q;
				end
			endcase
		end
	end

	assign key  = key_q;
	assign id   = id_q;
	assign flag = flag_q;
	assign hit  = (op.func == FN_DEL) ? (pre && !pre_l) : (mv == MV_NEW);

endmodule

@@ sv/time_sorted_event_table.sv @@
// Top level of the time sorted event table: a chain of tset_cell slots
// with the operation sequencer, id counter and result registers.
// Depends on tset_pkg and tset_cell.
//
// Usage: drive func, key, target_id and position and raise start while
// busy is low; the item is accepted at that clock edge. busy then stays
// high through a compare state, in which every slot compares its entry
// with the item in parallel and stores a flag, and a shift state, in
// which the slots move data one step left or right, or take the new
// entry, and the result registers load. In the cycle after the shift
// state busy is low and done is high for one cycle with status,
// entry_id, new_position and entry_count. A new item can be accepted in
// that same cycle. The sequence is set by the compare stage and the
// shift stage of the slot chain and does not depend on the table depth
// or fill.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset empties the table and clears the id counter; no clearing pass is
// needed since slots beyond the fill count are never read.
module time_sorted_event_table import tset_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       func,
	input  logic [KEY_W-1:0] key,
	input  logic [ID_W-1:0]  target_id,
	input  logic [POS_W-1:0] position,
	output logic             busy,
	output logic             done,
	output logic [1:0]       status,
	output logic [ID_W-1:0]  entry_id,
	output logic [POS_W-1:0] new_position,
	output logic [CNT_W-1:0] entry_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CMP   = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;

	logic [1:0]       state_q;
	logic [1:0]       func_q;
	logic [KEY_W-1:0] key_q;
	logic [ID_W-1:0]  tid_q;
	logic [POS_W-1:0] pos_q;
	logic [CW-1:0]    cnt_q;
	logic [ID_W-1:0]  nid_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [ID_W-1:0]  entry_id_q;
	logic [POS_W-1:0] new_position_q;

	op_t              op;
	logic             full;
	logic             in_range;
	logic             found;
	logic [ID_W-1:0]  pos_id;
	logic [ID_W-1:0]  new_id;
	logic [IW-1:0]    enc;

	logic [KEY_W-1:0] key_a [TABLE_DEPTH];
	logic [ID_W-1:0]  id_a  [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] flag_v;
	logic [TABLE_DEPTH-1:0] hit_v;
	logic [TABLE_DEPTH-1:0] pre_v;

	assign busy     = state_q != S_IDLE;
	assign full     = 32'(cnt_q) == 32'(TABLE_DEPTH);
	assign in_range = 32'(pos_q) < 32'(cnt_q);
	assign found    = pre_v[TABLE_DEPTH-1];

	always_comb begin
		op.func = func_q;
		op.key  = key_q;
		op.tid  = tid_q;
		op.pos  = pos_q;
		unique case (func_q)
			FN_INS: op.en = !full;
			FN_DEL: op.en = 1'b1;
			FN_UPD: op.en = in_range;
			default: op.en = 1'b0;
		endcase
	end

	always_comb begin
		pre_v = flag_v;
		for (int s = 1; s < TABLE_DEPTH; s = s * 2) begin
			pre_v = pre_v | (pre_v << s);
		end
	end

	always_comb begin
		enc    = '0;
		pos_id = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit_v[i]) enc = enc | IW'(i);
			if (32'(i) == 32'(pos_q)) pos_id = pos_id | id_a[i];
		end
	end

	assign new_id = (func_q == FN_UPD) ? pos_id : nid_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		tset_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.IDX(g)
		) u_cell (
			.clk      (clk),
			.op       (op),
			.cnt      (cnt_q),
			.cmp_en   (state_q == S_CMP),
			.apply_en (state_q == S_APPLY),
			.f_l      ((g == 0) ? 1'b1 : flag_v[(g == 0) ? 0 : g - 1]),
			.f_r      ((g == TABLE_DEPTH - 1) ? 1'b0
				: flag_v[(g == TABLE_DEPTH - 1) ? g : g + 1]),
			.pre      (pre_v[g]),
			.pre_l    ((g == 0) ? 1'b0 : pre_v[(g == 0) ? 0 : g - 1]),
			.new_id   (new_id),
			.left_key (key_a[(g == 0) ? 0 : g - 1]),
			.left_id  (id_a[(g == 0) ? 0 : g - 1]),
			.right_key(key_a[(g == TABLE_DEPTH - 1) ? g : g + 1]),
			.right_id (id_a[(g == TABLE_DEPTH - 1) ? g : g + 1]),
			.key      (key_a[g]),
			.id       (id_a[g]),
			.flag     (flag_v[g]),
			.hit      (hit_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			nid_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (func_q == FN_INS && !full) begin
						cnt_q <= cnt_q + CW'(1);
						nid_q <= nid_q + ID_W'(1);
					end else if (func_q == FN_DEL && found) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q <= func;
			key_q  <= key;
			tid_q  <= target_id;
			pos_q  <= position;
		end
		if (state_q == S_APPLY) begin
			unique case (func_q)
				FN_INS: begin
					status_q       <= full ? STS_FULL : STS_OK;
					entry_id_q     <= full ? '0 : nid_q;
					new_position_q <= full ? '0 : POS_W'(enc);
				end
				FN_DEL: begin
					status_q       <= found ? STS_OK : STS_NOT_FOUND;
					entry_id_q     <= tid_q;
					new_position_q <= found ? POS_W'(enc) : '0;
				end
				FN_UPD: begin
					status_q       <= in_range ? STS_OK : STS_RANGE;
					entry_id_q     <= in_range ? pos_id : '0;
					new_position_q <= in_range ? POS_W'(enc) : pos_q;
				end
				default: begin
					status_q       <= STS_OK;
					entry_id_q     <= '0;
					new_position_q <= '0;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign entry_id     = entry_id_q;
	assign new_position = new_position_q;
	assign entry_count  = CNT_W'(cnt_q);

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_APPLY)
		else $error("result strobe without a shift cycle");

	a_count_moves_in_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_APPLY))
		else $error("fill count changed outside the shift cycle");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY) |-> $onehot0(hit_v))
		else $error("more than one slot selected");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

endmodule
